/* design/bis_pkg.sv */
// Shared types, constants and helper functions of the bilinear image scaler.
// No dependencies; imported by every module of the block.
package bis_pkg;

  localparam int SRC_DIM_MAX = 256;
  localparam int DIM_W       = 9;
  localparam int DST_DIM_W   = 11;
  localparam int COORD_W     = 10;
  localparam int PIX_COORD_W = 8;
  localparam int ADDR_W      = 16;
  localparam int IMG_DEPTH   = 1 << ADDR_W;
  localparam int CHAN_W      = 8;
  localparam int RGB_W       = 3 * CHAN_W;
  localparam int FRAC_BITS   = 16;
  localparam int STEP_W      = DIM_W + FRAC_BITS;
  localparam int PROD_W      = COORD_W + STEP_W;
  localparam int POS_W       = PROD_W + 1;
  localparam int IPART_W     = POS_W - FRAC_BITS;
  localparam int NB_W        = IPART_W + 1;
  localparam int WT_W        = 2 * CHAN_W;
  localparam int ACC_W       = WT_W + CHAN_W;
  localparam int DIV_CNT_W   = $clog2(STEP_W + 1);

  localparam int CQ_DEPTH = 4;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);
  localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);
  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);
  localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

  localparam logic [POS_W-1:0]  POS_HALF  = POS_W'(1) << (FRAC_BITS - 1);
  localparam logic [CHAN_W-1:0] CHAN_FULL = '1;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  localparam logic [1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_DST_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_DST_HEIGHT = 2'd3;

  typedef struct packed {
    logic                   is_load;
    logic [COORD_W-1:0]     x;
    logic [COORD_W-1:0]     y;
    logic [RGB_W-1:0]       rgb;
    logic [3:0][ADDR_W-1:0] addr;
    logic [3:0]             nvalid;
    logic [CHAN_W-1:0]      u;
    logic [CHAN_W-1:0]      v;
  } cmd_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
  } res_t;

  // Neighbour lies inside the image or on its far edge.
  function automatic logic nb_ok(input logic signed [NB_W-1:0] c,
                                 input logic [DIM_W-1:0] dim);
    logic signed [NB_W-1:0] d;
    d = $signed(NB_W'(dim));
    return (c >= 0) && (c <= d);
  endfunction

  // Fold a coordinate on the far edge back onto the last pixel.
  function automatic logic [PIX_COORD_W-1:0] nb_clamp(input logic signed [NB_W-1:0] c,
                                                      input logic [DIM_W-1:0] dim);
    logic [DIM_W-1:0] last;
    last = dim - DIM_W'(1);
    if (c == $signed(NB_W'(dim))) begin
      return last[PIX_COORD_W-1:0];
    end
    return c[PIX_COORD_W-1:0];
  endfunction

endpackage

/* design/bis_step_div.sv */
// Bit-serial restoring divider: step = ((src_dim << 16) / dst_dim) + 1.
// Depends on bis_pkg; one quotient bit per cycle.
module bis_step_div import bis_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIM_W-1:0]     num_dim,
  input  logic [DST_DIM_W-1:0] den_dim,
  output logic                 busy,
  output logic [STEP_W-1:0]    step
);

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [STEP_W-1:0]    quo_r, quo_nxt;
  logic [DST_DIM_W-1:0] rem_r, rem_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic [DST_DIM_W:0]   trial;
  logic [DST_DIM_W:0]   diff;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    trial    = {rem_r, quo_r[STEP_W-1]};
    diff     = trial - {1'b0, den_dim};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(STEP_W);
      quo_nxt  = {num_dim, {FRAC_BITS{1'b0}}};
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_dim}) begin
        rem_nxt = diff[DST_DIM_W-1:0];
        quo_nxt = {quo_r[STEP_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DST_DIM_W-1:0];
        quo_nxt = {quo_r[STEP_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        step_nxt = quo_nxt + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
  end

  assign busy = busy_r;
  assign step = step_r;

endmodule

/* design/bis_front.sv */
// Front pipeline: source position, neighbour selection, weights and addresses.
// Depends on bis_pkg; feeds the command queue inside bis_back.
module bis_front import bis_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic                  req_type,
  input  logic [COORD_W-1:0]    pos_x,
  input  logic [COORD_W-1:0]    pos_y,
  input  logic [RGB_W-1:0]      rgb,
  input  logic [DIM_W-1:0]      src_w,
  input  logic [DIM_W-1:0]      src_h,
  input  logic [STEP_W-1:0]     step_x,
  input  logic [STEP_W-1:0]     step_y,
  input  logic                  q_full,
  output logic                  q_push,
  output cmd_t                  q_cmd,
  output logic                  advance
);

  // stage 1: captured item
  logic                s1_valid_r;
  logic                s1_type_r;
  logic [COORD_W-1:0]  s1_x_r, s1_y_r;
  logic [RGB_W-1:0]    s1_rgb_r;
  // stage 2: coordinate times step
  logic                s2_valid_r;
  logic                s2_type_r;
  logic [COORD_W-1:0]  s2_x_r, s2_y_r;
  logic [RGB_W-1:0]    s2_rgb_r;
  logic [PROD_W-1:0]   s2_px_r, s2_py_r;
  // stage 3: neighbours
  logic                   s3_valid_r, s3_keep_r;
  logic                   s3_type_r;
  logic [COORD_W-1:0]     s3_x_r, s3_y_r;
  logic [RGB_W-1:0]       s3_rgb_r;
  logic [PIX_COORD_W-1:0] s3_x0_r, s3_x1_r, s3_y0_r, s3_y1_r;
  logic [1:0]             s3_vx_r, s3_vy_r;
  logic [CHAN_W-1:0]      s3_u_r, s3_v_r;
  // stage 4: finished command
  logic                s4_valid_r, s4_keep_r;
  cmd_t                s4_cmd_r;

  logic                   en;
  logic [PROD_W-1:0]      px_prod, py_prod;
  logic signed [POS_W-1:0] pos_sx, pos_sy;
  logic signed [NB_W-1:0] ix0, ix1, iy0, iy1;
  logic                   keep3;
  logic [PIX_COORD_W-1:0] x0_c, x1_c, y0_c, y1_c;
  logic [1:0]             vx_c, vy_c;
  logic [DIM_W+PIX_COORD_W-1:0] row0, row1;
  cmd_t                   cmd_c;

  assign en      = !(s4_valid_r && s4_keep_r && q_full);
  assign advance = en;
  assign q_push  = s4_valid_r && s4_keep_r && !q_full;
  assign q_cmd   = s4_cmd_r;

  assign px_prod = PROD_W'(s1_x_r) * PROD_W'(step_x);
  assign py_prod = PROD_W'(s1_y_r) * PROD_W'(step_y);

  always_comb begin
    pos_sx = $signed({1'b0, s2_px_r}) + $signed(POS_W'(step_x >> 1)) - $signed(POS_HALF);
    pos_sy = $signed({1'b0, s2_py_r}) + $signed(POS_W'(step_y >> 1)) - $signed(POS_HALF);
    ix0    = $signed({pos_sx[POS_W-1], pos_sx[POS_W-1:FRAC_BITS]});
    iy0    = $signed({pos_sy[POS_W-1], pos_sy[POS_W-1:FRAC_BITS]});
    ix1    = ix0 + NB_W'(1);
    iy1    = iy0 + NB_W'(1);
    if (s2_type_r == REQ_LOAD) begin
      keep3 = (s2_x_r < COORD_W'(src_w)) && (s2_y_r < COORD_W'(src_h));
      x0_c  = s2_x_r[PIX_COORD_W-1:0];
      y0_c  = s2_y_r[PIX_COORD_W-1:0];
      x1_c  = x0_c;
      y1_c  = y0_c;
      vx_c  = 2'b11;
      vy_c  = 2'b11;
    end else begin
      keep3 = 1'b1;
      x0_c  = nb_clamp(ix0, src_w);
      x1_c  = nb_clamp(ix1, src_w);
      y0_c  = nb_clamp(iy0, src_h);
      y1_c  = nb_clamp(iy1, src_h);
      vx_c  = {nb_ok(ix1, src_w), nb_ok(ix0, src_w)};
      vy_c  = {nb_ok(iy1, src_h), nb_ok(iy0, src_h)};
    end
  end

  always_comb begin
    row0 = (DIM_W + PIX_COORD_W)'(s3_y0_r) * (DIM_W + PIX_COORD_W)'(src_w);
    row1 = (DIM_W + PIX_COORD_W)'(s3_y1_r) * (DIM_W + PIX_COORD_W)'(src_w);
    cmd_c.is_load = (s3_type_r == REQ_LOAD);
    cmd_c.x       = s3_x_r;
    cmd_c.y       = s3_y_r;
    cmd_c.rgb     = s3_rgb_r;
    // neighbour k: bit 0 selects the lower row, bit 1 the right column
    cmd_c.addr[0] = row0[ADDR_W-1:0] + ADDR_W'(s3_x0_r);
    cmd_c.addr[1] = row1[ADDR_W-1:0] + ADDR_W'(s3_x0_r);
    cmd_c.addr[2] = row0[ADDR_W-1:0] + ADDR_W'(s3_x1_r);
    cmd_c.addr[3] = row1[ADDR_W-1:0] + ADDR_W'(s3_x1_r);
    cmd_c.nvalid  = {s3_vy_r[1] & s3_vx_r[1], s3_vy_r[0] & s3_vx_r[1],
                     s3_vy_r[1] & s3_vx_r[0], s3_vy_r[0] & s3_vx_r[0]};
    cmd_c.u       = s3_u_r;
    cmd_c.v       = s3_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= accept;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
    if (en) begin
      s1_type_r <= req_type;
      s1_x_r    <= pos_x;
      s1_y_r    <= pos_y;
      s1_rgb_r  <= rgb;
      s2_type_r <= s1_type_r;
      s2_x_r    <= s1_x_r;
      s2_y_r    <= s1_y_r;
      s2_rgb_r  <= s1_rgb_r;
      s2_px_r   <= px_prod;
      s2_py_r   <= py_prod;
      s3_type_r <= s2_type_r;
      s3_x_r    <= s2_x_r;
      s3_y_r    <= s2_y_r;
      s3_rgb_r  <= s2_rgb_r;
      s3_keep_r <= keep3;
      s3_x0_r   <= x0_c;
      s3_x1_r   <= x1_c;
      s3_y0_r   <= y0_c;
      s3_y1_r   <= y1_c;
      s3_vx_r   <= vx_c;
      s3_vy_r   <= vy_c;
      s3_u_r    <= pos_sx[FRAC_BITS-1:FRAC_BITS-CHAN_W];
      s3_v_r    <= pos_sy[FRAC_BITS-1:FRAC_BITS-CHAN_W];
      s4_keep_r <= s3_keep_r;
      s4_cmd_r  <= cmd_c;
    end
  end

endmodule

/* design/bis_back.sv */
// Back end: command queue, source image memory, blend and result queue.
// Depends on bis_pkg; commands arrive from bis_front.
module bis_back import bis_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_push,
  input  cmd_t q_cmd,
  output logic q_full,
  input  logic res_pop,
  output logic res_empty,
  output res_t res_head
);

  cmd_t             cq_mem [CQ_DEPTH];
  logic [CQ_AW-1:0] cq_wr_r, cq_rd_r;
  logic [CQ_CW-1:0] cq_cnt_r;
  res_t             rq_mem [RQ_DEPTH];
  logic [RQ_AW-1:0] rq_wr_r, rq_rd_r;
  logic [RQ_CW-1:0] rq_cnt_r;
  logic [RQ_CW-1:0] credit_r;

  logic [RGB_W-1:0] img_mem [IMG_DEPTH];
  logic [RGB_W-1:0] rd_data_r;

  logic       cur_valid_r;
  cmd_t       cur_r;
  logic [1:0] k_r;

  logic                p_valid_r, p_first_r, p_last_r, p_nv_r;
  logic [WT_W-1:0]     p_wt_r;
  logic [COORD_W-1:0]  p_x_r, p_y_r;
  logic [2:0][ACC_W-1:0] acc_r;

  cmd_t              cq_head;
  logic              done, slot_free, take, cq_pop, rq_push, rq_pop, credit_inc;
  logic [CHAN_W-1:0] wu, wv;
  logic [WT_W-1:0]   wt;
  logic [2:0][ACC_W-1:0] sum;
  res_t              res_c;

  assign cq_head   = cq_mem[cq_rd_r];
  assign q_full    = (cq_cnt_r == CQ_CW'(CQ_DEPTH));
  assign done      = cur_r.is_load || (k_r == 2'd3);
  assign slot_free = !cur_valid_r || done;
  assign take      = slot_free && (cq_cnt_r != '0) &&
                     (cq_head.is_load || (credit_r < RQ_CW'(RQ_DEPTH)));
  assign cq_pop    = take;
  assign credit_inc = take && !cq_head.is_load;
  assign rq_pop    = res_pop && (rq_cnt_r != '0);
  assign rq_push   = p_valid_r && p_last_r;

  assign wu = k_r[1] ? cur_r.u : CHAN_FULL - cur_r.u;
  assign wv = k_r[0] ? cur_r.v : CHAN_FULL - cur_r.v;
  assign wt = WT_W'(wu) * WT_W'(wv);

  // channel 0 is red (top byte), 2 is blue
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = (p_first_r ? ACC_W'(0) : acc_r[c]) +
               (p_nv_r ? ACC_W'(p_wt_r) *
                         ACC_W'(rd_data_r[RGB_W-1-CHAN_W*c -: CHAN_W]) : ACC_W'(0));
    end
    res_c.x     = p_x_r;
    res_c.y     = p_y_r;
    res_c.red   = sum[0][ACC_W-1 -: CHAN_W];
    res_c.green = sum[1][ACC_W-1 -: CHAN_W];
    res_c.blue  = sum[2][ACC_W-1 -: CHAN_W];
  end

  // queues
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cq_wr_r  <= '0;
      cq_rd_r  <= '0;
      cq_cnt_r <= '0;
      rq_wr_r  <= '0;
      rq_rd_r  <= '0;
      rq_cnt_r <= '0;
      credit_r <= '0;
    end else begin
      if (q_push) cq_wr_r <= cq_wr_r + CQ_AW'(1);
      if (cq_pop) cq_rd_r <= cq_rd_r + CQ_AW'(1);
      cq_cnt_r <= cq_cnt_r + CQ_CW'(q_push) - CQ_CW'(cq_pop);
      if (rq_push) rq_wr_r <= rq_wr_r + RQ_AW'(1);
      if (rq_pop) rq_rd_r <= rq_rd_r + RQ_AW'(1);
      rq_cnt_r <= rq_cnt_r + RQ_CW'(rq_push) - RQ_CW'(rq_pop);
      credit_r <= credit_r + RQ_CW'(credit_inc) - RQ_CW'(rq_pop);
    end
    if (q_push) cq_mem[cq_wr_r] <= q_cmd;
    if (rq_push) rq_mem[rq_wr_r] <= res_c;
  end

  // sequencer: one memory access per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      p_valid_r   <= 1'b0;
    end else begin
      if (take) begin
        cur_valid_r <= 1'b1;
      end else if (slot_free) begin
        cur_valid_r <= 1'b0;
      end
      p_valid_r <= cur_valid_r && !cur_r.is_load;
    end
    if (take) begin
      cur_r <= cq_head;
      k_r   <= 2'd0;
    end else begin
      k_r <= k_r + 2'd1;
    end
    p_first_r <= (k_r == 2'd0);
    p_last_r  <= (k_r == 2'd3);
    p_nv_r    <= cur_r.nvalid[k_r];
    p_wt_r    <= wt;
    p_x_r     <= cur_r.x;
    p_y_r     <= cur_r.y;
    if (p_valid_r) acc_r <= sum;
  end

  always_ff @(posedge clk) begin
    if (cur_valid_r && cur_r.is_load) begin
      img_mem[cur_r.addr[0]] <= cur_r.rgb;
    end else begin
      rd_data_r <= img_mem[cur_r.addr[k_r]];
    end
  end

  assign res_empty = (rq_cnt_r == '0);
  assign res_head  = rq_mem[rq_rd_r];

`ifndef SYNTH
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= RQ_CW'(RQ_DEPTH))
    else $error("result credits exceed queue depth");
  a_rq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    rq_push |-> (rq_cnt_r < RQ_CW'(RQ_DEPTH)) || rq_pop)
    else $error("result queue overflow");
  a_rq_covered: assert property (@(posedge clk) disable iff (!rst_n)
    rq_cnt_r <= credit_r)
    else $error("result stored without credit");
  a_last_after_three: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_valid_r && !cur_r.is_load && k_r == 2'd3) |=> (p_valid_r && p_last_r))
    else $error("blend did not close after fourth read");
`endif

endmodule

/* design/bilinear_image_scaler.sv */
// Top level of the bilinear image scaler: configuration registers, step dividers,
// front pipeline and back end. Depends on bis_pkg, bis_step_div, bis_front, bis_back.
//
// Usage:
//   Input queue (push/full): req_type 0 loads one source pixel (in_red/green/blue)
//   at (pos_x,pos_y); req_type 1 asks for destination pixel (pos_x,pos_y).
//   A transfer happens on a clock edge with push high and full low.
//   Result queue (empty/pop): one result per destination request, none per load,
//   in request order; hold pop high to drain, a transfer needs empty low.
//   Configuration (cfg_valid/cfg_ready): cfg_ready is always high; cfg_index picks
//   src_width, src_height, dst_width or dst_height. Write only while idle.
// Timing:
//   A request makes four reads of the single-port image memory (one per neighbour),
//   and the back end holds each command until its last read is issued; a load
//   makes a single write. The front pipeline accepts an item every cycle while the
//   4-entry command queue has room, so items keep flowing in while results wait to
//   be popped.
// Reset and stalls:
//   After reset, and after every configuration write, the per-axis step is
//   recomputed by bit-serial dividers: full stays high until both have finished.
//   The image memory is not cleared: read only pixels that were loaded.
//   When the receiver stops popping, the 4-entry result queue fills, the back
//   end stops taking commands, the command queue fills and full rises.
module bilinear_image_scaler import bis_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic                 in_req_type,
  input  logic [COORD_W-1:0]   in_pos_x,
  input  logic [COORD_W-1:0]   in_pos_y,
  input  logic [CHAN_W-1:0]    in_red,
  input  logic [CHAN_W-1:0]    in_green,
  input  logic [CHAN_W-1:0]    in_blue,
  output logic                 empty,
  input  logic                 pop,
  output logic [COORD_W-1:0]   out_x,
  output logic [COORD_W-1:0]   out_y,
  output logic [CHAN_W-1:0]    out_red,
  output logic [CHAN_W-1:0]    out_green,
  output logic [CHAN_W-1:0]    out_blue,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [DST_DIM_W-1:0] cfg_data
);

  logic [DIM_W-1:0]     src_width_r, src_height_r;
  logic [DST_DIM_W-1:0] dst_width_r, dst_height_r;
  logic                 div_start_r;

  logic [DIM_W-1:0]     src_w, src_h;
  logic [DST_DIM_W-1:0] dst_w, dst_h;
  logic                 busy_x, busy_y;
  logic [STEP_W-1:0]    step_x, step_y;
  logic                 cfg_wr, accept, advance;
  logic                 q_push, q_full;
  cmd_t                 q_cmd;
  res_t                 res_head;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= DIM_W'(SRC_DIM_MAX);
      src_height_r <= DIM_W'(SRC_DIM_MAX);
      dst_width_r  <= DST_DIM_W'(SRC_DIM_MAX);
      dst_height_r <= DST_DIM_W'(SRC_DIM_MAX);
      div_start_r  <= 1'b1;
    end else begin
      div_start_r <= cfg_wr;
      if (cfg_wr) begin
        unique case (cfg_index)
          CFG_SRC_WIDTH:  src_width_r  <= cfg_data[DIM_W-1:0];
          CFG_SRC_HEIGHT: src_height_r <= cfg_data[DIM_W-1:0];
          CFG_DST_WIDTH:  dst_width_r  <= cfg_data;
          CFG_DST_HEIGHT: dst_height_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // saturate source size to 1..max, zero destination size counts as one
  always_comb begin
    src_w = (src_width_r == '0) ? DIM_W'(1) :
            (src_width_r > DIM_W'(SRC_DIM_MAX)) ? DIM_W'(SRC_DIM_MAX) : src_width_r;
    src_h = (src_height_r == '0) ? DIM_W'(1) :
            (src_height_r > DIM_W'(SRC_DIM_MAX)) ? DIM_W'(SRC_DIM_MAX) : src_height_r;
    dst_w = (dst_width_r == '0) ? DST_DIM_W'(1) : dst_width_r;
    dst_h = (dst_height_r == '0) ? DST_DIM_W'(1) : dst_height_r;
  end

  bis_step_div u_div_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start_r),
    .num_dim (src_w),
    .den_dim (dst_w),
    .busy    (busy_x),
    .step    (step_x)
  );

  bis_step_div u_div_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start_r),
    .num_dim (src_h),
    .den_dim (dst_h),
    .busy    (busy_y),
    .step    (step_y)
  );

  // hold input while the steps are being recomputed or the front is blocked
  assign full   = div_start_r || busy_x || busy_y || !advance;
  assign accept = push && !full;

  bis_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .req_type (in_req_type),
    .pos_x    (in_pos_x),
    .pos_y    (in_pos_y),
    .rgb      ({in_red, in_green, in_blue}),
    .src_w    (src_w),
    .src_h    (src_h),
    .step_x   (step_x),
    .step_y   (step_y),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd),
    .advance  (advance)
  );

  bis_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_push    (q_push),
    .q_cmd     (q_cmd),
    .q_full    (q_full),
    .res_pop   (pop),
    .res_empty (empty),
    .res_head  (res_head)
  );

  assign out_x     = res_head.x;
  assign out_y     = res_head.y;
  assign out_red   = res_head.red;
  assign out_green = res_head.green;
  assign out_blue  = res_head.blue;

endmodule

/* test/bis_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the bilinear image scaler: watches the input, result and register channels,
// keeps its own copy of the source image and predicts every destination pixel. Needs bis_pkg.
module bis_checker import bis_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic                 full,
  input  logic                 in_req_type,
  input  logic [COORD_W-1:0]   in_pos_x,
  input  logic [COORD_W-1:0]   in_pos_y,
  input  logic [CHAN_W-1:0]    in_red,
  input  logic [CHAN_W-1:0]    in_green,
  input  logic [CHAN_W-1:0]    in_blue,
  input  logic                 empty,
  input  logic                 pop,
  input  logic [COORD_W-1:0]   out_x,
  input  logic [COORD_W-1:0]   out_y,
  input  logic [CHAN_W-1:0]    out_red,
  input  logic [CHAN_W-1:0]    out_green,
  input  logic [CHAN_W-1:0]    out_blue,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [DST_DIM_W-1:0] cfg_data,
  output int                   errors,
  output int                   pending,
  output int                   loads_seen,
  output int                   pixels_seen
);

  logic [RGB_W-1:0]     image_mem [0:IMG_DEPTH-1];
  logic [DIM_W-1:0]     src_w_reg, src_h_reg;
  logic [DST_DIM_W-1:0] dst_w_reg, dst_h_reg;
  res_t                 pixel_expect [$];

  assign pending = pixel_expect.size();

  function automatic int src_dim(input logic [DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > SRC_DIM_MAX) return SRC_DIM_MAX;
    return int'(d);
  endfunction

  // Signed 48.16 source position along one axis
  function automatic longint axis_pos(input int coord, input int sdim, input int ddim);
    longint step;
    step = (longint'(sdim) << FRAC_BITS) / ddim + 1;
    return -(longint'(1) << (FRAC_BITS - 1)) + (step >>> 1) + longint'(coord) * step;
  endfunction

  function automatic res_t blend_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    int w, h, u, v;
    longint sx, sy, ix, iy, nx, ny;
    int wt [4];
    int acc [3];
    logic [RGB_W-1:0] p;
    res_t r;
    w = src_dim(src_w_reg);
    h = src_dim(src_h_reg);
    sx = axis_pos(x, w, (dst_w_reg == 0) ? 1 : dst_w_reg);
    sy = axis_pos(y, h, (dst_h_reg == 0) ? 1 : dst_h_reg);
    ix = sx >>> FRAC_BITS;
    iy = sy >>> FRAC_BITS;
    u = int'((sx & 64'hFFFF) >> 8);
    v = int'((sy & 64'hFFFF) >> 8);
    wt[0] = (255 - u) * (255 - v);
    wt[1] = (255 - u) * v;
    wt[2] = u * (255 - v);
    wt[3] = u * v;
    acc = '{0, 0, 0};
    for (int k = 0; k < 4; k++) begin
      ny = iy + (k & 1);
      nx = ix + (k >> 1);
      // neighbours beyond the image add nothing; the far edge folds back
      if (ny < 0 || ny > h || nx < 0 || nx > w) begin
        p = '0;
      end else begin
        if (ny == h) ny--;
        if (nx == w) nx--;
        p = image_mem[ny * w + nx];
      end
      for (int c = 0; c < 3; c++) acc[c] += wt[k] * p[RGB_W-1-CHAN_W*c -: CHAN_W];
    end
    r.x = x;
    r.y = y;
    r.red = CHAN_W'(acc[0] >> 16);
    r.green = CHAN_W'(acc[1] >> 16);
    r.blue = CHAN_W'(acc[2] >> 16);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    res_t e;
    int w, h;
    if (!rst_n) begin
      src_w_reg <= DIM_W'(256);
      src_h_reg <= DIM_W'(256);
      dst_w_reg <= DST_DIM_W'(256);
      dst_h_reg <= DST_DIM_W'(256);
      pixel_expect.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SRC_WIDTH:  src_w_reg <= cfg_data[DIM_W-1:0];
          CFG_SRC_HEIGHT: src_h_reg <= cfg_data[DIM_W-1:0];
          CFG_DST_WIDTH:  dst_w_reg <= cfg_data;
          CFG_DST_HEIGHT: dst_h_reg <= cfg_data;
        endcase
      end
      if (push && !full) begin
        if (in_req_type == REQ_LOAD) begin
          w = src_dim(src_w_reg);
          h = src_dim(src_h_reg);
          loads_seen++;
          if (in_pos_x < w && in_pos_y < h)
            image_mem[in_pos_y * w + in_pos_x] = {in_red, in_green, in_blue};
        end else begin
          pixel_expect.push_back(blend_pixel(in_pos_x, in_pos_y));
        end
      end
      if (pop && !empty) begin
        pixels_seen++;
        if (pixel_expect.size() == 0) begin
          report_mismatch("unexpected result x", out_x, -1);
        end else begin
          e = pixel_expect.pop_front();
          if (out_x != e.x) report_mismatch("out_x", out_x, e.x);
          if (out_y != e.y) report_mismatch("out_y", out_y, e.y);
          if (out_red != e.red) report_mismatch("out_red", out_red, e.red);
          if (out_green != e.green) report_mismatch("out_green", out_green, e.green);
          if (out_blue != e.blue) report_mismatch("out_blue", out_blue, e.blue);
        end
      end
    end
  end

endmodule

/* test/tb_bilinear_image_scaler.sv */
`timescale 1ns / 1ps
// Top of the bilinear image scaler testbench: clock, reset, stimulus and verdict.
// Depends on bis_pkg, the block itself and bis_checker.
module tb_bilinear_image_scaler;
  import bis_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 push = 1'b0;
  logic                 full;
  logic                 in_req_type = REQ_LOAD;
  logic [COORD_W-1:0]   in_pos_x = '0;
  logic [COORD_W-1:0]   in_pos_y = '0;
  logic [CHAN_W-1:0]    in_red = '0;
  logic [CHAN_W-1:0]    in_green = '0;
  logic [CHAN_W-1:0]    in_blue = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [COORD_W-1:0]   out_x;
  logic [COORD_W-1:0]   out_y;
  logic [CHAN_W-1:0]    out_red, out_green, out_blue;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [1:0]           cfg_index = CFG_SRC_WIDTH;
  logic [DST_DIM_W-1:0] cfg_data = '0;

  int errors, pending, loads_seen, pixels_seen;
  int send_gap_max = 5;   // sender idles 0..this between transfers
  int recv_gap_max = 5;   // receiver idles 0..this between transfers
  bit hold_results = 1'b0; // ask the receiver for one long hold-off
  bit busy_push = 1'b0;    // push currently held high by the sender

  always #5 clk = ~clk;

  bilinear_image_scaler dut (.*);

  bis_checker u_checker (.*);

  // Receiver: random pops, with an occasional long hold-off counted here.
  initial begin
    int g;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_results) begin
        pop <= 1'b0;
        repeat (300) @(posedge clk);
        hold_results = 1'b0;
      end
      g = $urandom_range(0, recv_gap_max);
      if (g > 0) begin
        pop <= 1'b0;
        repeat (g) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  // Offer one item and hold it until the block takes the transfer.
  task automatic send_item(input logic kind, input int x, input int y);
    int g;
    g = $urandom_range(0, send_gap_max);
    if (g > 0 && busy_push) begin
      push <= 1'b0;
      busy_push = 1'b0;
      repeat (g) @(posedge clk);
    end else if (g > 0) begin
      repeat (g) @(posedge clk);
    end
    push <= 1'b1;
    busy_push = 1'b1;
    in_req_type <= kind;
    in_pos_x <= COORD_W'(x);
    in_pos_y <= COORD_W'(y);
    in_red <= CHAN_W'($urandom_range(0, 255));
    in_green <= CHAN_W'($urandom_range(0, 255));
    in_blue <= CHAN_W'($urandom_range(0, 255));
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Drop push and wait until every expected pixel has come back.
  task automatic drain_results();
    push <= 1'b0;
    busy_push = 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // loads leave nothing to wait for; let the pipeline settle
    repeat (30) @(posedge clk);
  endtask

  // Leave valid high; the caller drops it after the last write.
  task automatic write_reg(input logic [1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= DST_DIM_W'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Reconfigure, load the whole source image, then mix loads and pixel requests.
  task automatic run_phase(input int sw, input int sh, input int dw, input int dh,
                           input int n_req, input bit with_hold);
    int w, h, dwe, dhe, x, y;
    drain_results();
    write_reg(CFG_SRC_WIDTH, sw);
    write_reg(CFG_SRC_HEIGHT, sh);
    write_reg(CFG_DST_WIDTH, dw);
    write_reg(CFG_DST_HEIGHT, dh);
    cfg_valid <= 1'b0;
    w = (sw % 512 == 0) ? 1 : ((sw % 512 > 256) ? 256 : sw % 512);
    h = (sh % 512 == 0) ? 1 : ((sh % 512 > 256) ? 256 : sh % 512);
    dwe = (dw % 2048 == 0) ? 1 : dw % 2048;
    dhe = (dh % 2048 == 0) ? 1 : dh % 2048;
    // every pixel must be loaded before any request can read it
    for (int yy = 0; yy < h; yy++)
      for (int xx = 0; xx < w; xx++) send_item(REQ_LOAD, xx, yy);
    for (int i = 0; i < n_req; i++) begin
      if (with_hold && i == 4) hold_results = 1'b1;
      if (i == n_req / 2) drain_results();
      case ($urandom_range(0, 9))
        0: send_item(REQ_LOAD, $urandom_range(0, 1023), $urandom_range(0, 1023));
        1: send_item(REQ_LOAD, $urandom_range(0, w - 1), $urandom_range(0, h - 1));
        2: send_item(REQ_PIXEL, $urandom_range(0, 1023), $urandom_range(0, 1023));
        default: begin
          x = $urandom_range(0, (dwe > 1023) ? 1023 : dwe);
          y = $urandom_range(0, (dhe > 1023) ? 1023 : dhe);
          send_item(REQ_PIXEL, x, y);
        end
      endcase
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: 2x2 source onto 4x4, corners, far edge and far beyond the image.
    run_phase(2, 2, 4, 4, 0, 1'b0);
    send_item(REQ_PIXEL, 0, 0);
    send_item(REQ_PIXEL, 3, 3);
    send_item(REQ_PIXEL, 0, 3);
    send_item(REQ_PIXEL, 3, 0);
    send_item(REQ_PIXEL, 4, 4);
    send_item(REQ_PIXEL, 1, 2);
    send_item(REQ_PIXEL, 1023, 1023);
    send_item(REQ_PIXEL, 0, 1023);
    send_item(REQ_PIXEL, 682, 341);
    send_item(REQ_LOAD, 2, 0);
    send_item(REQ_LOAD, 1023, 1023);
    send_item(REQ_LOAD, 1, 1);
    send_item(REQ_PIXEL, 2, 2);

    // Extremes: zero sizes, oversize source, widest destination field values.
    send_gap_max = 0; recv_gap_max = 0;
    run_phase(0, 0, 0, 0, 40, 1'b0);
    send_gap_max = 5; recv_gap_max = 5;
    run_phase(511, 1, 2047, 1, 60, 1'b1);
    run_phase(1, 256, 1, 1024, 60, 1'b0);
    run_phase(257, 1, 1, 2047, 30, 1'b0);

    for (int p = 0; p < 6; p++) begin
      send_gap_max = (p % 3 == 0) ? 0 : 5;
      recv_gap_max = (p % 2 == 0) ? 5 : 0;
      run_phase($urandom_range(1, 12), $urandom_range(1, 12),
                $urandom_range(1, 40), $urandom_range(1, 40), 20, p == 2);
    end

    drain_results();
    $display("Covered %0d loads and %0d destination pixels over 11 size settings.",
             loads_seen, pixels_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("Timeout waiting for the block");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
